### hdl/buffer_slot_lookup_allocate_macros.svh
// Assertion macros for the buffer slot table.
`ifndef BUFFER_SLOT_LOOKUP_ALLOCATE_MACROS_SVH
`define BUFFER_SLOT_LOOKUP_ALLOCATE_MACROS_SVH

`ifndef ASSERT_OFF
// Checked outside reset.
`define BSLA_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every edge, reset included.
`define BSLA_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BSLA_ASSERT(name, clk, rst, prop, msg)
`define BSLA_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

### hdl/bsla_pkg.sv
package bsla_pkg;

  localparam int NUM_SLOTS_DEFAULT = 64;
  localparam int COUNT_W = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  localparam logic REQ_ACQUIRE = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_NO_FREE     = 2'd1;
  localparam logic [1:0] STATUS_BAD_RELEASE = 2'd2;

  typedef struct packed {
    logic        req_type;
    logic [31:0] rel_id;
    logic [31:0] block_number;
    logic        want_new;
    logic [31:0] rel_block_count;
    logic [5:0]  release_slot;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  slot_index;
    logic        hit;
    logic [31:0] block_used;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] rel;
    logic [31:0] blk;
  } tag_entry_t;

endpackage

### hdl/bsla_ram.sv
module bsla_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/bsla_out_reg.sv
module bsla_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  bsla_pkg::out_item_t  load_item,
  output logic                 free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bsla_pkg::out_item_t  out_item
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= load_item;
    end
  end

endmodule

### hdl/buffer_slot_lookup_allocate.sv
// Fully associative buffer slot table with round-robin replacement. Tags and
// reference counts live in two single-port-read RAMs scanned one slot per
// cycle. After reset a clearing pass zeroes both RAMs; no item is taken
// meanwhile. An acquire scans the tags for a matching slot; a miss adds a
// free-slot search from the round-robin pointer. A release reads the slot's
// count and then decrements it. Results sit in an output register, so the
// next item is taken while a result waits to be consumed.
`include "buffer_slot_lookup_allocate_macros.svh"

module buffer_slot_lookup_allocate #(
  parameter int NUM_SLOTS = bsla_pkg::NUM_SLOTS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bsla_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output bsla_pkg::out_item_t out_item
);

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam int CNT_W = bsla_pkg::COUNT_W;
  localparam int TAG_W = $bits(bsla_pkg::tag_entry_t);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  typedef enum logic [6:0] {
    ST_CLEAR   = 7'b0000001,
    ST_IDLE    = 7'b0000010,
    ST_MATCH   = 7'b0000100,
    ST_FREE    = 7'b0001000,
    ST_REL_RD  = 7'b0010000,
    ST_REL_CHK = 7'b0100000,
    ST_FIN     = 7'b1000000
  } state_t;

  function automatic logic [IDX_W-1:0] inc_wrap(input logic [IDX_W-1:0] a);
    inc_wrap = (a == LAST_IDX) ? '0 : IDX_W'(a + 1'b1);
  endfunction

  state_t              state;
  logic [IDX_W-1:0]    rd_addr;
  logic [IDX_W-1:0]    iss;
  logic                iss_done;
  logic                chk_vld;
  logic [IDX_W-1:0]    chk_addr;
  logic                chk_last;
  logic [IDX_W-1:0]    next_victim;
  logic [31:0]         req_rel;
  logic [31:0]         req_blk;
  logic [5:0]          req_slot;
  logic [IDX_W-1:0]    rel_idx;
  bsla_pkg::out_item_t res;

  bsla_pkg::tag_entry_t tag_rd;
  bsla_pkg::tag_entry_t tag_wdata;
  logic                 tag_we;
  logic [IDX_W-1:0]     tag_waddr;
  logic [CNT_W-1:0]     cnt_rd;
  logic [CNT_W-1:0]     cnt_wdata;
  logic                 cnt_we;
  logic [IDX_W-1:0]     cnt_waddr;
  logic [IDX_W-1:0]     cnt_raddr;

  logic match_hit;
  logic free_hit;
  logic out_free;
  logic in_range;

  assign in_ready  = (state == ST_IDLE);
  assign match_hit = chk_vld && tag_rd.valid && (tag_rd.rel == req_rel)
                     && (tag_rd.blk == req_blk);
  assign free_hit  = chk_vld && (cnt_rd == '0);
  assign in_range  = (32'(in_item.release_slot) < 32'(NUM_SLOTS));

  bsla_ram #(.WIDTH(TAG_W), .DEPTH(NUM_SLOTS)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_wdata),
    .raddr (iss),
    .rdata (tag_rd)
  );

  bsla_ram #(.WIDTH(CNT_W), .DEPTH(NUM_SLOTS)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rd)
  );

  bsla_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (state == ST_FIN && out_free),
    .load_item (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // Memory write and read port selection.
  always_comb begin
    tag_we    = 1'b0;
    tag_waddr = chk_addr;
    tag_wdata = '0;
    cnt_we    = 1'b0;
    cnt_waddr = chk_addr;
    cnt_wdata = '0;
    cnt_raddr = iss;
    case (state)
      ST_CLEAR: begin
        tag_we    = 1'b1;
        tag_waddr = rd_addr;
        cnt_we    = 1'b1;
        cnt_waddr = rd_addr;
      end
      ST_MATCH: begin
        if (match_hit) begin
          cnt_we    = 1'b1;
          cnt_wdata = (cnt_rd == bsla_pkg::COUNT_MAX) ? cnt_rd : CNT_W'(cnt_rd + 1'b1);
        end
      end
      ST_FREE: begin
        cnt_raddr = rd_addr;
        if (free_hit) begin
          tag_we          = 1'b1;
          tag_wdata.valid = 1'b1;
          tag_wdata.rel   = req_rel;
          tag_wdata.blk   = req_blk;
          cnt_we          = 1'b1;
          cnt_wdata       = CNT_W'(1);
        end
      end
      ST_REL_RD: begin
        cnt_raddr = rel_idx;
      end
      ST_REL_CHK: begin
        cnt_waddr = rel_idx;
        if (cnt_rd != '0) begin
          cnt_we    = 1'b1;
          cnt_wdata = CNT_W'(cnt_rd - 1'b1);
        end
      end
      default: begin
      end
    endcase
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          req_rel  <= in_item.rel_id;
          req_blk  <= in_item.want_new ? in_item.rel_block_count : in_item.block_number;
          req_slot <= in_item.release_slot;
          rel_idx  <= IDX_W'(in_item.release_slot);
          res.slot_index <= in_item.release_slot;
          res.hit        <= 1'b0;
          res.block_used <= '0;
          res.status     <= bsla_pkg::STATUS_BAD_RELEASE;
        end
      end
      ST_MATCH: begin
        chk_addr <= iss;
        chk_last <= (iss == LAST_IDX);
        if (match_hit) begin
          res.slot_index <= 6'(chk_addr);
          res.hit        <= 1'b1;
          res.block_used <= req_blk;
          res.status     <= bsla_pkg::STATUS_OK;
        end
      end
      ST_FREE: begin
        chk_addr <= rd_addr;
        chk_last <= iss_done || (iss == LAST_IDX);
        if (free_hit) begin
          res.slot_index <= 6'(chk_addr);
          res.hit        <= 1'b0;
          res.block_used <= req_blk;
          res.status     <= bsla_pkg::STATUS_OK;
        end else if (chk_vld && chk_last) begin
          res.slot_index <= '0;
          res.hit        <= 1'b0;
          res.block_used <= req_blk;
          res.status     <= bsla_pkg::STATUS_NO_FREE;
        end
      end
      ST_REL_CHK: begin
        res.slot_index <= req_slot;
        res.hit        <= 1'b0;
        res.block_used <= '0;
        res.status     <= (cnt_rd != '0) ? bsla_pkg::STATUS_OK
                                         : bsla_pkg::STATUS_BAD_RELEASE;
      end
      default: begin
      end
    endcase
  end

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      rd_addr     <= '0;
      iss         <= '0;
      iss_done    <= 1'b0;
      chk_vld     <= 1'b0;
      next_victim <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          rd_addr <= inc_wrap(rd_addr);
          if (rd_addr == LAST_IDX) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          iss      <= '0;
          iss_done <= 1'b0;
          chk_vld  <= 1'b0;
          if (in_valid) begin
            if (in_item.req_type == bsla_pkg::REQ_ACQUIRE) begin
              state <= ST_MATCH;
            end else if (in_range) begin
              state <= ST_REL_RD;
            end else begin
              state <= ST_FIN;
            end
          end
        end
        ST_MATCH: begin
          // issue slot iss, check the slot issued in the previous cycle
          if (!match_hit && chk_vld && chk_last) begin
            state    <= ST_FREE;
            iss      <= '0;
            iss_done <= 1'b0;
            chk_vld  <= 1'b0;
            rd_addr  <= next_victim;
          end else begin
            chk_vld <= !iss_done;
            if (iss == LAST_IDX) begin
              iss_done <= 1'b1;
            end else if (!iss_done) begin
              iss <= IDX_W'(iss + 1'b1);
            end
            if (match_hit) begin
              state <= ST_FIN;
            end
          end
        end
        ST_FREE: begin
          chk_vld <= !iss_done;
          rd_addr <= inc_wrap(rd_addr);
          if (iss == LAST_IDX) begin
            iss_done <= 1'b1;
          end else if (!iss_done) begin
            iss <= IDX_W'(iss + 1'b1);
          end
          if (free_hit) begin
            next_victim <= inc_wrap(chk_addr);
            state       <= ST_FIN;
          end else if (chk_vld && chk_last) begin
            state <= ST_FIN;
          end
        end
        ST_REL_RD: begin
          state <= ST_REL_CHK;
        end
        ST_REL_CHK: begin
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `BSLA_ASSERT(a_no_accept_in_clear, clk, rst,
    (state == ST_CLEAR) |-> !in_ready,
    "item accepted during clearing pass")
  `BSLA_ASSERT(a_victim_in_range, clk, rst,
    32'(next_victim) < 32'(NUM_SLOTS),
    "victim pointer beyond table")
  `BSLA_ASSERT(a_hit_ok, clk, rst,
    (out_valid && out_item.hit) |-> (out_item.status == bsla_pkg::STATUS_OK),
    "hit reported with error status")
  `BSLA_ASSERT(a_fin_not_from_idle_acquire, clk, rst,
    (state == ST_MATCH) |=> (state == ST_MATCH || state == ST_FREE || state == ST_FIN),
    "tag scan left to wrong state")

endmodule
